>>> hw/rtl/slfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sync/length frame receiver.
package slfr_pkg;

    // Header size in bytes, sync word included (8 to 16)
    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned COUNT_W      = 4;

    // Header byte positions
    localparam logic [COUNT_W-1:0] IDX_SYNC_DONE = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] IDX_CMD_HI    = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] IDX_CMD_LO    = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] IDX_LEN_HI    = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] IDX_LEN_LO    = COUNT_W'(7);
    localparam logic [COUNT_W:0]   HEADER_END    = (COUNT_W+1)'(HEADER_BYTES);

    localparam logic [31:0] SYNC_RESET   = 32'hD0F9_EE5D;
    localparam logic [15:0] LEN_OVERHEAD = 16'd4;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_SHORT  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] command_code;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
    } result_t;

endpackage

>>> hw/rtl/slfr_parser.sv
`timescale 1ns / 1ps
// Frame parser: sync hunt, header collection and payload counting per byte.
module slfr_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata,
    input  logic                  byte_accept,
    input  logic [7:0]            rx_byte,
    output logic                  res_push,
    output slfr_pkg::result_t     res_data
);

    logic [31:0]                      sync_word_reg;
    slfr_pkg::phase_t                 phase_reg, phase_next;
    logic [31:0]                      window_reg, window_next;
    logic [slfr_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [15:0]                      command_reg, command_next;
    logic [15:0]                      length_reg, length_next;
    logic [15:0]                      remaining_reg, remaining_next;

    logic [31:0]                      window_shift;
    logic                             sync_hit;
    logic [slfr_pkg::COUNT_W:0]       count_inc;
    logic                             header_done;
    logic                             length_short;
    logic [15:0]                      plen_head;
    logic [15:0]                      plen_data;
    logic                             data_last;

    // Decode conditions shared by state and result logic
    always_comb
    begin
        window_shift = {window_reg[23:0], rx_byte};
        sync_hit     = (window_shift == sync_word_reg);
        count_inc    = {1'b0, count_reg} + (slfr_pkg::COUNT_W+1)'(1);
        header_done  = (count_inc >= slfr_pkg::HEADER_END);

        command_next = command_reg;
        length_next  = length_reg;
        if (phase_reg == slfr_pkg::PH_HEAD)
        begin
            if (count_reg == slfr_pkg::IDX_CMD_HI)
                command_next = {rx_byte, command_reg[7:0]};
            else if (count_reg == slfr_pkg::IDX_CMD_LO)
                command_next = {command_reg[15:8], rx_byte};
            else if (count_reg == slfr_pkg::IDX_LEN_HI)
                length_next = {rx_byte, length_reg[7:0]};
            else if (count_reg == slfr_pkg::IDX_LEN_LO)
                length_next = {length_reg[15:8], rx_byte};
        end

        length_short = (length_next < slfr_pkg::LEN_OVERHEAD);
        plen_head    = length_next - slfr_pkg::LEN_OVERHEAD;
        plen_data    = (length_reg >= slfr_pkg::LEN_OVERHEAD)
                       ? (length_reg - slfr_pkg::LEN_OVERHEAD) : 16'd0;
        data_last    = (remaining_reg <= 16'd1);
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            slfr_pkg::PH_HEAD:
            begin
                if (header_done)
                    phase_next = (length_short || plen_head == 16'd0)
                                 ? slfr_pkg::PH_HUNT : slfr_pkg::PH_DATA;
            end
            slfr_pkg::PH_DATA:
            begin
                if (data_last)
                    phase_next = slfr_pkg::PH_HUNT;
            end
            default:
            begin
                phase_next = sync_hit ? slfr_pkg::PH_HEAD : slfr_pkg::PH_HUNT;
            end
        endcase
    end

    // Counters, window and result
    always_comb
    begin
        window_next    = window_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        res_push       = 1'b0;
        res_data       = '0;
        res_data.command_code = command_next;
        unique case (phase_reg)
            slfr_pkg::PH_HEAD:
            begin
                if (header_done)
                begin
                    res_push = 1'b1;
                    if (length_short)
                    begin
                        res_data.kind = slfr_pkg::KIND_SHORT;
                        res_data.last = 1'b1;
                        window_next    = '0;
                        count_next     = '0;
                        remaining_next = '0;
                    end
                    else if (plen_head == 16'd0)
                    begin
                        res_data.kind = slfr_pkg::KIND_HEADER;
                        res_data.last = 1'b1;
                        window_next    = '0;
                        count_next     = '0;
                        remaining_next = '0;
                    end
                    else
                    begin
                        res_data.kind           = slfr_pkg::KIND_HEADER;
                        res_data.payload_length = plen_head;
                        count_next     = '0;
                        remaining_next = plen_head;
                    end
                end
                else
                begin
                    count_next = count_inc[slfr_pkg::COUNT_W-1:0];
                end
            end
            slfr_pkg::PH_DATA:
            begin
                res_push                = 1'b1;
                res_data.kind           = slfr_pkg::KIND_DATA;
                res_data.payload_length = plen_data;
                res_data.data_byte      = rx_byte;
                res_data.last           = data_last;
                if (data_last)
                begin
                    window_next    = '0;
                    count_next     = '0;
                    remaining_next = '0;
                end
                else
                begin
                    remaining_next = remaining_reg - 16'd1;
                end
            end
            default:
            begin
                if (sync_hit)
                begin
                    window_next = '0;
                    count_next  = slfr_pkg::IDX_SYNC_DONE;
                end
                else
                begin
                    window_next = window_shift;
                end
            end
        endcase
        res_push = res_push & byte_accept;
    end

    // Hold the sync pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sync_word_reg <= slfr_pkg::SYNC_RESET;
        else if (cfg_we)
            sync_word_reg <= cfg_wdata;
    end

    // Advance parser state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= slfr_pkg::PH_HUNT;
            window_reg    <= '0;
            count_reg     <= '0;
            command_reg   <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg     <= phase_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            command_reg   <= command_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

>>> hw/rtl/slfr_out_buf.sv
`timescale 1ns / 1ps
// Result output register with a skid entry.
module slfr_out_buf
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  slfr_pkg::result_t     push_data,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_stall,
    output slfr_pkg::result_t     out_data
);

    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    slfr_pkg::result_t    main_reg;
    slfr_pkg::result_t    skid_reg;
    logic                 main_free;

    assign main_free = !main_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Track occupancy of both entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move results: skid drains first, new request fills the free slot
    always_ff @(posedge clk)
    begin
        if (main_free)
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        else if (push)
            skid_reg <= push_data;
    end

endmodule

>>> hw/rtl/sync_length_frame_receiver.sv
`timescale 1ns / 1ps
// Top level of the sync-word, length-prefixed frame receiver.
//
// Takes one received byte per cycle. Each accepted byte updates the parser in
// the same cycle and, when it completes a header or carries payload, places
// one result in a two-entry output buffer (output register plus skid entry),
// so one byte a cycle is sustained while out_stall stays low; in_stall rises
// only once both entries hold results. Results: kind 0 header (command code,
// payload length), kind 1 payload byte, kind 2 length below four. The last
// result of a frame has last set. Checksum bytes are skipped unchecked.
// sync_word is written through cfg_we/cfg_wdata and applies at the next
// compare; it resets to 0xD0F9EE5D.
module sync_length_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] command_code,
    output logic [15:0] payload_length,
    output logic [7:0]  data_byte,
    output logic        last
);

    logic                 byte_accept;
    logic                 res_push;
    logic                 buf_full;
    slfr_pkg::result_t    res_data;
    slfr_pkg::result_t    out_data;

    assign in_stall    = buf_full;
    assign byte_accept = in_valid && !buf_full;

    slfr_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .res_push    (res_push),
        .res_data    (res_data)
    );

    slfr_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Unpack the result request onto the ports
    assign kind           = out_data.kind;
    assign command_code   = out_data.command_code;
    assign payload_length = out_data.payload_length;
    assign data_byte      = out_data.data_byte;
    assign last           = out_data.last;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the sync-word, length-prefixed frame receiver.
module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int CHECK_BYTES  = int'(slfr_pkg::HEADER_BYTES) - 8;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [15:0] command_code;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;

    sync_length_frame_receiver dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .command_code   (command_code),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .last           (last)
    );

    // Bytes waiting to be offered and results the parser copy predicts
    logic [7:0]        rx_backlog[$];
    slfr_pkg::result_t pending_results[$];
    slfr_pkg::result_t oldest_result;

    // Parser copy: state and the sync register
    logic [31:0]      sync_pattern = slfr_pkg::SYNC_RESET;
    logic [31:0]      hunt_win     = 32'd0;
    slfr_pkg::phase_t rx_phase     = slfr_pkg::PH_HUNT;
    logic [3:0]       hdr_count    = 4'd0;
    logic [15:0]      frame_cmd    = 16'd0;
    logic [15:0]      frame_len    = 16'd0;
    logic [15:0]      bytes_left   = 16'd0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int queued_bytes   = 0;
    logic hold_req     = 1'b0;
    int   hold_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Go back to hunting for the sync word
    function automatic void restart_hunt();
        rx_phase   = slfr_pkg::PH_HUNT;
        hunt_win   = 32'd0;
        hdr_count  = 4'd0;
        bytes_left = 16'd0;
    endfunction

    function automatic void expect_result(input slfr_pkg::kind_t k,
                                          input logic [15:0] plen,
                                          input logic [7:0] data, input logic fin);
        slfr_pkg::result_t r;
        r.kind           = k;
        r.command_code   = frame_cmd;
        r.payload_length = plen;
        r.data_byte      = data;
        r.last           = fin;
        pending_results = {pending_results, r};
    endfunction

    // Advance the parser copy by one received byte
    function automatic void deframe_byte(input logic [7:0] b);
        logic [3:0]  idx;
        logic [15:0] plen;
        case (rx_phase)
            slfr_pkg::PH_HEAD:
            begin
                idx = hdr_count;
                if (idx == slfr_pkg::IDX_CMD_HI)
                    frame_cmd[15:8] = b;
                else if (idx == slfr_pkg::IDX_CMD_LO)
                    frame_cmd[7:0] = b;
                else if (idx == slfr_pkg::IDX_LEN_HI)
                    frame_len[15:8] = b;
                else if (idx == slfr_pkg::IDX_LEN_LO)
                    frame_len[7:0] = b;
                if (int'(idx) + 1 >= int'(slfr_pkg::HEADER_BYTES))
                begin
                    if (frame_len < slfr_pkg::LEN_OVERHEAD)
                    begin
                        expect_result(slfr_pkg::KIND_SHORT, 16'd0, 8'd0, 1'b1);
                        restart_hunt();
                    end
                    else
                    begin
                        plen = frame_len - slfr_pkg::LEN_OVERHEAD;
                        if (plen == 16'd0)
                        begin
                            expect_result(slfr_pkg::KIND_HEADER, 16'd0, 8'd0, 1'b1);
                            restart_hunt();
                        end
                        else
                        begin
                            expect_result(slfr_pkg::KIND_HEADER, plen, 8'd0, 1'b0);
                            rx_phase   = slfr_pkg::PH_DATA;
                            bytes_left = plen;
                            hdr_count  = 4'd0;
                        end
                    end
                end
                else
                    hdr_count = idx + 4'd1;
            end
            slfr_pkg::PH_DATA:
            begin
                plen = (frame_len >= slfr_pkg::LEN_OVERHEAD)
                       ? frame_len - slfr_pkg::LEN_OVERHEAD : 16'd0;
                if (bytes_left <= 16'd1)
                begin
                    expect_result(slfr_pkg::KIND_DATA, plen, b, 1'b1);
                    restart_hunt();
                end
                else
                begin
                    expect_result(slfr_pkg::KIND_DATA, plen, b, 1'b0);
                    bytes_left = bytes_left - 16'd1;
                end
            end
            default:
            begin
                hunt_win = {hunt_win[23:0], b};
                if (hunt_win == sync_pattern)
                begin
                    rx_phase  = slfr_pkg::PH_HEAD;
                    hdr_count = slfr_pkg::IDX_SYNC_DONE;
                    hunt_win  = 32'd0;
                end
                else
                    rx_phase = slfr_pkg::PH_HUNT;
            end
        endcase
    endfunction

    // Driver: predict each accepted request, then offer the next byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
            if (!in_valid || !in_stall)
            begin
                if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_backlog.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    rx_byte  <= 8'($urandom);
                end
            end
        end
    end

    // Long receiver hold-off, counted down on its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: check each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d cmd %h len %0d data %h last %b",
                                 kind, command_code, payload_length, data_byte, last);
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (kind !== oldest_result.kind
                        || command_code !== oldest_result.command_code
                        || payload_length !== oldest_result.payload_length
                        || data_byte !== oldest_result.data_byte
                        || last !== oldest_result.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected kind %0d cmd %h len %0d data %h ",
                                      "last %b, got kind %0d cmd %h len %0d data %h last %b"},
                                     oldest_result.kind, oldest_result.command_code,
                                     oldest_result.payload_length, oldest_result.data_byte,
                                     oldest_result.last, kind, command_code,
                                     payload_length, data_byte, last);
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        rx_backlog = {rx_backlog, b};
        queued_bytes++;
    endtask

    // Queue the sync word from byte position first (0 is the top byte)
    task automatic queue_sync(input int first);
        for (int i = first; i < 4; i++)
            queue_byte(sync_pattern[8*(3-i) +: 8]);
    endtask

    task automatic queue_header(input logic [15:0] cmd, input logic [15:0] len);
        queue_byte(cmd[15:8]);
        queue_byte(cmd[7:0]);
        queue_byte(len[15:8]);
        queue_byte(len[7:0]);
        repeat (CHECK_BYTES) queue_byte(8'($urandom));
    endtask

    // Queue one piece of traffic: mostly whole frames, some noise and broken syncs
    task automatic queue_frame();
        int pick;
        int first;
        int len;
        pick = $urandom_range(99);
        if (pick < 8)
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
        else if (pick < 14)
        begin
            queue_sync(4 - $urandom_range(1, 3));
            queue_byte(8'($urandom));
        end
        else
        begin
            // Leading zero bytes of the sync word match on a cleared window
            first = 0;
            while (first < 3 && sync_pattern[8*(3-first) +: 8] == 8'h00)
                first++;
            queue_sync(first);
            pick = $urandom_range(99);
            if (pick < 10)
                len = $urandom_range(0, 3);
            else if (pick < 20)
                len = 4;
            else if (pick < 23)
                len = $urandom_range(16'h0100, 16'h0110);
            else
                len = $urandom_range(5, 20);
            queue_header(16'($urandom), 16'(len));
            for (int i = 4; i < len; i++)
                queue_byte(8'($urandom));
        end
    endtask

    task automatic queue_traffic(input int n);
        int goal;
        goal = queued_bytes + n;
        while (queued_bytes < goal)
            queue_frame();
    endtask

    // Hold the sender until every request is taken and every result has come
    task automatic wait_idle();
        @(negedge clk);
        while (rx_backlog.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sync(input logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        sync_pattern = v;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset sync word, largest command, empty payload
        queue_sync(0);
        queue_header(16'hFFFF, 16'h0004);
        wait_idle();

        // Sync write in the middle of a header, then a one-byte payload
        write_sync(32'hFFFF_FFFF);
        queue_sync(0);
        queue_byte(8'h80);
        queue_byte(8'h01);
        wait_idle();
        write_sync(32'h0000_00AB);
        queue_byte(8'h00);
        queue_byte(8'h05);
        repeat (CHECK_BYTES) queue_byte(8'hFF);
        queue_byte(8'h00);
        // One-byte sync on a cleared window, short length
        queue_sync(3);
        queue_header(16'h1234, 16'h0002);
        wait_idle();

        // Random traffic under each idling pattern and sync setting
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_sync(32'h0000_0000);
                1: write_sync(slfr_pkg::SYNC_RESET);
                2: write_sync({16'h0000, 16'($urandom)});
                default: write_sync($urandom);
            endcase
            send_idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 8 : 0;
            recv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 8 : 0;
            queue_traffic(450);
            wait_idle();
        end

        // Back-pressure: receiver holds off while the sender keeps offering
        write_sync(32'hFFFF_FFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        queue_traffic(60);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
